### rtl/core/lmc_pkg.sv
package lmc_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 64;
    localparam int WORD_BITS   = 64;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [WORD_BITS-1:0]   word_t;
    typedef logic [IDX_W-1:0]       age_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [CAPACITY-1:0]    slot_vec_t;

endpackage

### rtl/core/lru_memo_cache_core.sv
// Channel   Handshake                Beat contents
// cfg       cfg_valid / cfg_ready    cache_enable
// in        in_valid / in_ready      key_first, key_second, key_third, fill_value
// out       out_valid / out_ready    hit, result_value, evicted, evicted_first,
//                                    evicted_second, evicted_third, evicted_value
//
// An input beat lands in the input register; once the output register can take it,
// the lookup, LRU update and eviction choice are done and the result is in the output
// register, which drives out_valid. One beat per cycle is sustained while out_ready
// holds; the combinational loop through the entry store and ages sets that rate.
// Reset empties the cache and sets cache_enable; no clearing pass is needed.
// A stalled output holds both registers, and in_ready drops only when both are full.
module lru_memo_cache_core
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cache_enable,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          key_first,
    input  logic [63:0]          key_second,
    input  logic [63:0]          key_third,
    input  logic [63:0]          fill_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [63:0]          result_value,
    output logic                 evicted,
    output logic [63:0]          evicted_first,
    output logic [63:0]          evicted_second,
    output logic [63:0]          evicted_third,
    output logic [63:0]          evicted_value
);

    logic                 enable_reg;

    logic                 in_valid_reg;
    lmc_pkg::handle_t     k1_reg;
    lmc_pkg::handle_t     k2_reg;
    lmc_pkg::handle_t     k3_reg;
    lmc_pkg::word_t       fill_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    lmc_pkg::word_t       result_value_reg;
    logic                 evicted_reg;
    lmc_pkg::word_t       evicted_first_reg;
    lmc_pkg::word_t       evicted_second_reg;
    lmc_pkg::word_t       evicted_third_reg;
    lmc_pkg::word_t       evicted_value_reg;

    lmc_pkg::slot_vec_t   valid_reg;
    lmc_pkg::slot_vec_t   valid_next;
    lmc_pkg::age_t        age_reg  [lmc_pkg::CAPACITY];
    lmc_pkg::age_t        age_next [lmc_pkg::CAPACITY];
    lmc_pkg::count_t      live_reg;
    lmc_pkg::count_t      live_next;
    lmc_pkg::handle_t     first_reg  [lmc_pkg::CAPACITY];
    lmc_pkg::handle_t     second_reg [lmc_pkg::CAPACITY];
    lmc_pkg::handle_t     third_reg  [lmc_pkg::CAPACITY];
    lmc_pkg::word_t       value_reg  [lmc_pkg::CAPACITY];

    logic                 fire;
    logic                 update;
    lmc_pkg::slot_vec_t   match;
    lmc_pkg::slot_vec_t   found_oh;
    lmc_pkg::slot_vec_t   victim_oh;
    lmc_pkg::slot_vec_t   valid_after;
    lmc_pkg::slot_vec_t   free_oh;
    logic                 hit_any;
    logic                 evict;
    logic                 match_seen;
    logic                 free_seen;
    lmc_pkg::age_t        hit_age;
    lmc_pkg::word_t       hit_value;
    lmc_pkg::handle_t     vic_first;
    lmc_pkg::handle_t     vic_second;
    lmc_pkg::handle_t     vic_third;
    lmc_pkg::word_t       vic_value;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign update    = fire && enable_reg;

    // Lookup, victim choice and free slot choice.
    always_comb
    begin
        match_seen = 1'b0;
        free_seen  = 1'b0;
        hit_age    = '0;
        hit_value  = '0;
        vic_first  = '0;
        vic_second = '0;
        vic_third  = '0;
        vic_value  = '0;
        for (int i = 0; i < lmc_pkg::CAPACITY; i++)
        begin
            match[i] = valid_reg[i] && (first_reg[i] == k1_reg) &&
                       (second_reg[i] == k2_reg) && (third_reg[i] == k3_reg);
            found_oh[i] = match[i] && !match_seen;
            match_seen  = match_seen || match[i];
        end
        hit_any = match_seen;
        // Valid ages always form the ranks 0 .. live-1, so when the store is
        // one short of full the oldest entry is the one ranked CAPACITY-2.
        evict = !hit_any && (live_reg == lmc_pkg::count_t'(lmc_pkg::CAPACITY - 1));
        for (int i = 0; i < lmc_pkg::CAPACITY; i++)
        begin
            victim_oh[i] = evict && valid_reg[i] &&
                           (age_reg[i] == lmc_pkg::age_t'(lmc_pkg::CAPACITY - 2));
            if (found_oh[i])
            begin
                hit_age   = hit_age | age_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (victim_oh[i])
            begin
                vic_first  = vic_first | first_reg[i];
                vic_second = vic_second | second_reg[i];
                vic_third  = vic_third | third_reg[i];
                vic_value  = vic_value | value_reg[i];
            end
        end
        valid_after = valid_reg & ~victim_oh;
        for (int i = 0; i < lmc_pkg::CAPACITY; i++)
        begin
            free_oh[i] = !valid_after[i] && !free_seen;
            free_seen  = free_seen || !valid_after[i];
        end
    end

    // Next state of the recency ranks, valid bits and live count.
    always_comb
    begin
        valid_next = valid_reg;
        live_next  = live_reg;
        for (int i = 0; i < lmc_pkg::CAPACITY; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (hit_any)
        begin
            for (int i = 0; i < lmc_pkg::CAPACITY; i++)
            begin
                if (found_oh[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = age_reg[i] + lmc_pkg::age_t'(1);
                end
            end
        end
        else
        begin
            valid_next = valid_after | free_oh;
            if (!evict)
            begin
                live_next = live_reg + lmc_pkg::count_t'(1);
            end
            for (int i = 0; i < lmc_pkg::CAPACITY; i++)
            begin
                if (free_oh[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_after[i] &&
                         (age_reg[i] < lmc_pkg::age_t'(lmc_pkg::CAPACITY - 1)))
                begin
                    age_next[i] = age_reg[i] + lmc_pkg::age_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enable_reg <= cache_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            live_reg      <= '0;
            for (int i = 0; i < lmc_pkg::CAPACITY; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (update)
            begin
                valid_reg <= valid_next;
                live_reg  <= live_next;
                for (int i = 0; i < lmc_pkg::CAPACITY; i++)
                begin
                    age_reg[i] <= age_next[i];
                end
            end
        end
    end

    // Payload registers: input beat, result beat and the entry store.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            k1_reg   <= lmc_pkg::handle_t'(key_first);
            k2_reg   <= lmc_pkg::handle_t'(key_second);
            k3_reg   <= lmc_pkg::handle_t'(key_third);
            fill_reg <= fill_value;
        end
        if (fire)
        begin
            hit_reg            <= update && hit_any;
            result_value_reg   <= (update && hit_any) ? hit_value : fill_reg;
            evicted_reg        <= update && evict;
            evicted_first_reg  <= update ? lmc_pkg::word_t'(vic_first) : '0;
            evicted_second_reg <= update ? lmc_pkg::word_t'(vic_second) : '0;
            evicted_third_reg  <= update ? lmc_pkg::word_t'(vic_third) : '0;
            evicted_value_reg  <= update ? vic_value : '0;
        end
        for (int i = 0; i < lmc_pkg::CAPACITY; i++)
        begin
            if (update && !hit_any && free_oh[i])
            begin
                first_reg[i]  <= k1_reg;
                second_reg[i] <= k2_reg;
                third_reg[i]  <= k3_reg;
                value_reg[i]  <= fill_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign result_value   = result_value_reg;
    assign evicted        = evicted_reg;
    assign evicted_first  = evicted_first_reg;
    assign evicted_second = evicted_second_reg;
    assign evicted_third  = evicted_third_reg;
    assign evicted_value  = evicted_value_reg;

endmodule
